// File: hdl/esodo_pkg.sv
// ----------------------------------------------------------------------------
// esodo_pkg
// shared types, constants and the arctangent table of the smoothed odometry
// ----------------------------------------------------------------------------
package esodo_pkg;

    // default geometry of the fixed-point formats
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POS_FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE = 1'b1;
    localparam logic [CFG_W-1:0]     SCALE_RST      = 16'd5462;
    localparam logic [CFG_W-1:0]     WHEEL_BASE_RST = 16'd5760;

    // 2*pi in q3.29
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // cordic
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_ZW    = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // divide by three of the three-sample sum magnitude
    localparam int DIV3_W = 34;

    // multiply-divide unit
    localparam int MUL_AW = 49;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DEN_W  = 64;
    localparam int QMAG_W = 63;
    localparam logic [QMAG_W-1:0] QMAX = 63'h4000_0000_0000_0000;

    // turn angle divider
    localparam int ANG_NW = 49;
    localparam int ANG_DW = 48;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } odo_in_t;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic        [15:0] heading;
        logic signed [15:0] x_cm;
        logic signed [15:0] y_cm;
    } odo_out_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AVG_GO,
        S_AVG_WAIT,
        S_DELTA,
        S_MULA,
        S_MULB,
        S_MULC,
        S_COS0_GO,
        S_COS0_WAIT,
        S_ANG_GO,
        S_ANG_WAIT,
        S_COS1_GO,
        S_COS1_WAIT,
        S_MD_GO,
        S_MD_WAIT,
        S_UPDATE,
        S_OUT
    } odo_state_t;

    // atan(2^-k) as a 32-bit binary angle
    function automatic logic [31:0] atan_val(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051D;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2E;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517C;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A2F;
            5'd19:   v = 32'h0000_0517;
            5'd20:   v = 32'h0000_028B;
            5'd21:   v = 32'h0000_0145;
            5'd22:   v = 32'h0000_00A2;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0028;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0002;
            5'd29:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/encoder_smoothed_odometry_core.sv
// ----------------------------------------------------------------------------
// encoder_smoothed_odometry_core
// three-sample smoothed differential-drive odometry with serial arithmetic
// ----------------------------------------------------------------------------
// sequence: the first two samples are stored and give no result; from the
//   third on, each transfer runs the averaging divide (34 steps), one
//   30-step cordic pass, on a turning step the turn angle divider
//   (ANGLE_BITS + 70 steps) and a second 30-step cordic pass, then the
//   serial multiply-divide (33 + 82 bit steps)
// samples: one at a time, the next transfer is taken once the
//   result sits in the output register
// reset: asynchronous, active low; pose, heading, averages and fill clear,
//   configuration returns to scale 5462 and wheel base 5760
module encoder_smoothed_odometry_core #(
    parameter int ANGLE_BITS    = esodo_pkg::ANGLE_BITS_DEF,
    parameter int POS_FRAC_BITS = esodo_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  esodo_pkg::odo_in_t                sample,
    output logic                              pose_valid,
    input  logic                              pose_ready,
    output esodo_pkg::odo_out_t               pose,
    input  logic                              cfg_we,
    input  logic [esodo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [esodo_pkg::CFG_W-1:0]       cfg_data
);
    import esodo_pkg::*;

    localparam int STR_SH  = 46 - POS_FRAC_BITS;
    localparam int TURN_SH = 39 - POS_FRAC_BITS;
    localparam logic [DEN_W-1:0] STR_DEN = DEN_W'(1) << STR_SH;

    // ---------------- state ----------------
    odo_state_t state_reg, state_next;

    logic [CFG_W-1:0]         scale_reg;
    logic [CFG_W-1:0]         wheel_base_reg;
    logic [31:0]              left_ring_reg [3];
    logic [31:0]              right_ring_reg [3];
    logic [1:0]               slot_reg;
    logic [1:0]               fill_reg;
    logic [31:0]              prev_left_reg;
    logic [31:0]              prev_right_reg;
    logic signed [31:0]       pos_x_reg;
    logic signed [31:0]       pos_y_reg;
    logic [ANGLE_BITS-1:0]    angle_reg;

    // per-step working registers
    logic                     lneg_reg;
    logic                     rneg_reg;
    logic signed [31:0]       dl_reg;
    logic signed [32:0]       diff_reg;
    logic signed [32:0]       total_reg;
    logic                     straight_reg;
    logic [MUL_AW-1:0]        amag_reg;
    logic                     aneg_reg;
    logic [ANG_NW-1:0]        n_reg;
    logic [ANG_DW-1:0]        dv_reg;
    logic signed [CORDIC_W-1:0] c0_reg;
    logic signed [CORDIC_W-1:0] s0_reg;
    logic [ANGLE_BITS-1:0]    th1_reg;

    odo_out_t                 pose_reg;
    logic                     pose_valid_reg;

    // ---------------- control ----------------
    logic sample_xfer;
    logic pose_load;
    logic avg_start, cos_start, ang_start, md_start;

    assign sample_xfer = sample_valid && sample_ready;

    // ---------------- unit connections ----------------
    logic signed [33:0]       lsum, rsum;
    logic [DIV3_W-1:0]        lmag, rmag;
    logic [DIV3_W-1:0]        lq, rq;
    logic                     l_done, r_done;
    logic [31:0]              la, ra;
    logic [31:0]              dl_new, dr_new;

    logic [31:0]              cos_angle;
    logic signed [CORDIC_W-1:0] cos_c, cos_s;
    logic                     cos_done;

    logic [ANGLE_BITS-1:0]    turn;
    logic                     ang_done;

    logic [MUL_BW-1:0]        mul_a;
    logic [CFG_W-1:0]         mul_b;
    logic [MUL_AW-1:0]        mul_p;
    logic [CFG_W-1:0]         w_eff;
    logic [31:0]              dl_mag;
    logic [MUL_BW-1:0]        diff_mag;
    logic [MUL_BW-1:0]        total_mag;

    logic signed [34:0]       bx_src, by_src;
    logic [MUL_BW-1:0]        bx_mag, by_mag;
    logic                     nx, ny;
    logic [DEN_W-1:0]         md_den;
    logic signed [DEN_W-1:0]  dx, dy;
    logic                     x_done, y_done;

    logic signed [63:0]       sx, sy;
    logic signed [31:0]       px_new, py_new;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_RST;
            wheel_base_reg <= WHEEL_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE:      scale_reg      <= cfg_data;
                CFG_WHEEL_BASE: wheel_base_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // a wheel base of zero is taken as one
    assign w_eff = (wheel_base_reg == '0) ? CFG_W'(1) : wheel_base_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (sample_xfer && (fill_reg >= 2'd2))
                    state_next = S_AVG_GO;
            S_AVG_GO:    state_next = S_AVG_WAIT;
            S_AVG_WAIT:  if (l_done) state_next = S_DELTA;
            S_DELTA:     state_next = S_MULA;
            S_MULA:      state_next = straight_reg ? S_COS0_GO : S_MULB;
            S_MULB:      state_next = S_MULC;
            S_MULC:      state_next = S_COS0_GO;
            S_COS0_GO:   state_next = S_COS0_WAIT;
            S_COS0_WAIT:
                if (cos_done)
                    state_next = straight_reg ? S_MD_GO : S_ANG_GO;
            S_ANG_GO:    state_next = S_ANG_WAIT;
            S_ANG_WAIT:  if (ang_done) state_next = S_COS1_GO;
            S_COS1_GO:   state_next = S_COS1_WAIT;
            S_COS1_WAIT: if (cos_done) state_next = S_MD_GO;
            S_MD_GO:     state_next = S_MD_WAIT;
            S_MD_WAIT:   if (x_done) state_next = S_UPDATE;
            S_UPDATE:    state_next = S_OUT;
            S_OUT:       if (pose_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        sample_ready = (state_reg == S_IDLE);
        avg_start    = (state_reg == S_AVG_GO);
        cos_start    = (state_reg == S_COS0_GO) || (state_reg == S_COS1_GO);
        ang_start    = (state_reg == S_ANG_GO);
        md_start     = (state_reg == S_MD_GO);
        // the output register frees itself on the same edge as its transfer
        pose_load    = (state_reg == S_OUT) && (!pose_valid_reg || pose_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- sample ring ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 2'd0;
            fill_reg <= 2'd0;
        end
        else if (sample_xfer)
        begin
            slot_reg <= (slot_reg >= 2'd2) ? 2'd0 : slot_reg + 2'd1;
            if (fill_reg != 2'd3)
                fill_reg <= fill_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            left_ring_reg[(slot_reg >= 2'd3) ? 2'd0 : slot_reg]  <= sample.left_count;
            right_ring_reg[(slot_reg >= 2'd3) ? 2'd0 : slot_reg] <= sample.right_count;
        end
    end

    // ---------------- averaging ----------------
    // exact mean of three, rounded half away from zero: (|sum| + 1) / 3
    assign lsum = 34'(signed'(left_ring_reg[0])) + 34'(signed'(left_ring_reg[1]))
                + 34'(signed'(left_ring_reg[2]));
    assign rsum = 34'(signed'(right_ring_reg[0])) + 34'(signed'(right_ring_reg[1]))
                + 34'(signed'(right_ring_reg[2]));
    assign lmag = (lsum[33] ? DIV3_W'(-lsum) : DIV3_W'(lsum)) + DIV3_W'(1);
    assign rmag = (rsum[33] ? DIV3_W'(-rsum) : DIV3_W'(rsum)) + DIV3_W'(1);

    esodo_div3 u_div3_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (lmag),
        .quotient (lq),
        .done     (l_done)
    );

    esodo_div3 u_div3_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (avg_start),
        .dividend (rmag),
        .quotient (rq),
        .done     (r_done)
    );

    assign la     = lneg_reg ? -lq[31:0] : lq[31:0];
    assign ra     = rneg_reg ? -rq[31:0] : rq[31:0];
    // wheel deltas wrap to 32 bits
    assign dl_new = la - prev_left_reg;
    assign dr_new = ra - prev_right_reg;

    // ---------------- shared narrow multiplier ----------------
    assign dl_mag    = dl_reg[31] ? 32'(-dl_reg) : 32'(dl_reg);
    assign diff_mag  = diff_reg[32] ? MUL_BW'(-diff_reg) : MUL_BW'(diff_reg);
    assign total_mag = total_reg[32] ? MUL_BW'(-total_reg) : MUL_BW'(total_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = w_eff;
        unique case (state_reg)
            S_MULA:
            begin
                mul_a = straight_reg ? MUL_BW'(dl_mag) : diff_mag;
                mul_b = scale_reg;
            end
            S_MULB:  mul_a = MUL_BW'(TWO_PI_Q29);
            S_MULC:  mul_a = total_mag;
            default: ;
        endcase
    end

    assign mul_p = MUL_AW'(mul_a) * MUL_AW'(mul_b);

    // ---------------- sine and cosine ----------------
    assign cos_angle = (state_reg == S_COS1_GO)
                     ? {th1_reg, {(32-ANGLE_BITS){1'b0}}}
                     : {angle_reg, {(32-ANGLE_BITS){1'b0}}};

    esodo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cos_start),
        .angle (cos_angle),
        .cos_q (cos_c),
        .sin_q (cos_s),
        .done  (cos_done)
    );

    // ---------------- turn angle ----------------
    esodo_angdiv #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_angdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_start),
        .num   (n_reg),
        .den   (dv_reg),
        .neg   (diff_reg[32]),
        .turn  (turn),
        .done  (ang_done)
    );

    // ---------------- position increments ----------------
    // straight: dist * sin / cos; turning: base * (c0 - c1) and (s1 - s0)
    assign bx_src = straight_reg ? 35'(s0_reg) : (35'(c0_reg) - 35'(cos_c));
    assign by_src = straight_reg ? 35'(c0_reg) : (35'(cos_s) - 35'(s0_reg));
    assign bx_mag = bx_src[34] ? MUL_BW'(-bx_src) : MUL_BW'(bx_src);
    assign by_mag = by_src[34] ? MUL_BW'(-by_src) : MUL_BW'(by_src);
    // a negative wheel difference flips both turning increments
    assign nx     = aneg_reg ^ bx_src[34] ^ (!straight_reg && diff_reg[32]);
    assign ny     = aneg_reg ^ by_src[34] ^ (!straight_reg && diff_reg[32]);
    assign md_den = straight_reg ? STR_DEN : (DEN_W'(diff_mag) << TURN_SH);

    esodo_muldiv u_muldiv_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .a_mag  (amag_reg),
        .b_mag  (bx_mag),
        .neg    (nx),
        .den    (md_den),
        .result (dx),
        .done   (x_done)
    );

    esodo_muldiv u_muldiv_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .a_mag  (amag_reg),
        .b_mag  (by_mag),
        .neg    (ny),
        .den    (md_den),
        .result (dy),
        .done   (y_done)
    );

    // saturating position update
    assign sx = 64'(pos_x_reg) + dx;
    assign sy = 64'(pos_y_reg) + dy;

    always_comb
    begin
        if (sx > 64'sd2147483647)
            px_new = 32'sh7FFF_FFFF;
        else if (sx < -64'sd2147483648)
            px_new = 32'sh8000_0000;
        else
            px_new = sx[31:0];
        if (sy > 64'sd2147483647)
            py_new = 32'sh7FFF_FFFF;
        else if (sy < -64'sd2147483648)
            py_new = 32'sh8000_0000;
        else
            py_new = sy[31:0];
    end

    // ---------------- working registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_AVG_GO:
            begin
                lneg_reg <= lsum[33];
                rneg_reg <= rsum[33];
            end
            S_DELTA:
            begin
                dl_reg       <= dl_new;
                diff_reg     <= 33'(signed'(dl_new)) - 33'(signed'(dr_new));
                total_reg    <= 33'(signed'(dl_new)) + 33'(signed'(dr_new));
                straight_reg <= (dl_new == dr_new);
            end
            S_MULA:
            begin
                amag_reg <= mul_p;
                aneg_reg <= dl_reg[31];
                n_reg    <= mul_p;
            end
            S_MULB:  dv_reg <= mul_p[ANG_DW-1:0];
            S_MULC:
            begin
                amag_reg <= mul_p;
                aneg_reg <= total_reg[32];
            end
            S_COS0_WAIT:
                if (cos_done)
                begin
                    c0_reg <= cos_c;
                    s0_reg <= cos_s;
                end
            S_ANG_WAIT:
                if (ang_done)
                    th1_reg <= angle_reg + turn;
            default: ;
        endcase
    end

    // ---------------- pose state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            angle_reg      <= '0;
        end
        else if (state_reg == S_DELTA)
        begin
            prev_left_reg  <= la;
            prev_right_reg <= ra;
        end
        else if (state_reg == S_UPDATE)
        begin
            pos_x_reg <= px_new;
            pos_y_reg <= py_new;
            if (!straight_reg)
                angle_reg <= th1_reg;
        end
    end

    // ---------------- result formatting ----------------
    // whole centimetres, rounded half away from zero, clamped to 16 bits
    function automatic logic signed [15:0] to_cm(input logic signed [31:0] p);
        logic [32:0] m;
        logic [32:0] q;
        logic signed [15:0] v;
        m = p[31] ? ({1'b0, ~p} + 33'd1) : {1'b0, p};
        q = (m + (33'd1 << (POS_FRAC_BITS - 1))) >> POS_FRAC_BITS;
        if (!p[31])
            v = (q > 33'd32767) ? 16'sh7FFF : signed'(q[15:0]);
        else
            v = (q > 33'd32768) ? 16'sh8000 : signed'(-q[15:0]);
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pose_valid_reg <= 1'b0;
        else if (pose_load)
            pose_valid_reg <= 1'b1;
        else if (pose_ready)
            pose_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pose_load)
        begin
            pose_reg.x_pos   <= pos_x_reg;
            pose_reg.y_pos   <= pos_y_reg;
            pose_reg.heading <= 16'({angle_reg, 16'h0000} >> ANGLE_BITS);
            pose_reg.x_cm    <= to_cm(pos_x_reg);
            pose_reg.y_cm    <= to_cm(pos_y_reg);
        end
    end

    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;

    // ---------------- checks ----------------
    // both averaging dividers run in lock step
    assert property (@(posedge clk) disable iff (!rst_n) l_done == r_done)
        else $error("averaging dividers out of step");

    // both increment units finish together
    assert property (@(posedge clk) disable iff (!rst_n) x_done == y_done)
        else $error("increment units out of step");

    // a result appears only after the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result without a completed step");

    // the ring slot never points past the last entry
    assert property (@(posedge clk) disable iff (!rst_n) slot_reg != 2'd3)
        else $error("ring slot out of range");

    // a turning step commits the new heading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && !straight_reg) |=> angle_reg == $past(th1_reg))
        else $error("heading not committed");

endmodule

// File: hdl/esodo_div3.sv
// ----------------------------------------------------------------------------
// esodo_div3
// bit-serial division by three, one quotient bit per cycle
// ----------------------------------------------------------------------------
module esodo_div3 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [esodo_pkg::DIV3_W-1:0]  dividend,
    output logic [esodo_pkg::DIV3_W-1:0]  quotient,
    output logic                          done
);
    import esodo_pkg::*;

    localparam int CNT_W = $clog2(DIV3_W + 1);

    logic [DIV3_W-1:0] sh_reg;
    logic [1:0]        rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [2:0]        trial;
    logic              qbit;
    logic [1:0]        rem_next;

    assign trial    = {rem_reg, sh_reg[DIV3_W-1]};
    assign qbit     = (trial >= 3'd3);
    assign rem_next = qbit ? 2'(trial - 3'd3) : trial[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(DIV3_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= 2'd0;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= {sh_reg[DIV3_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign quotient = sh_reg;
    assign done     = done_reg;

endmodule

// File: hdl/esodo_cordic.sv
// ----------------------------------------------------------------------------
// esodo_cordic
// iterative rotation cordic, sine and cosine in q30, one step per cycle
// ----------------------------------------------------------------------------
module esodo_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [31:0]                          angle,
    output logic signed [esodo_pkg::CORDIC_W-1:0] cos_q,
    output logic signed [esodo_pkg::CORDIC_W-1:0] sin_q,
    output logic                                 done
);
    import esodo_pkg::*;

    logic signed [CORDIC_W-1:0]  x_reg;
    logic signed [CORDIC_W-1:0]  y_reg;
    logic signed [CORDIC_ZW-1:0] z_reg;
    logic                        flip_reg;
    logic [4:0]                  k_reg;
    logic                        active_reg;
    logic                        done_reg;
    logic signed [CORDIC_W-1:0]  xs;
    logic signed [CORDIC_W-1:0]  ys;
    logic signed [CORDIC_ZW-1:0] at;
    logic                        flip;
    logic [31:0]                 a_fold;

    // second and third quadrants are folded by half a turn
    assign flip   = angle[31] ^ angle[30];
    assign a_fold = {angle[31] ^ flip, angle[30:0]};

    assign xs = x_reg >>> k_reg;
    assign ys = y_reg >>> k_reg;
    assign at = CORDIC_ZW'(atan_val(k_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            done_reg <= active_reg && (k_reg == 5'(CORDIC_STEPS - 1));
            if (start)
            begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (active_reg)
            begin
                if (k_reg == 5'(CORDIC_STEPS - 1))
                    active_reg <= 1'b0;
                else
                    k_reg <= k_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= CORDIC_ZW'(signed'(a_fold));
            flip_reg <= flip;
        end
        else if (active_reg)
        begin
            if (!z_reg[CORDIC_ZW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cos_q = flip_reg ? -x_reg : x_reg;
    assign sin_q = flip_reg ? -y_reg : y_reg;
    assign done  = done_reg;

endmodule

// File: hdl/esodo_angdiv.sv
// ----------------------------------------------------------------------------
// esodo_angdiv
// turn angle divider, restoring long division one quotient bit per cycle
// ----------------------------------------------------------------------------
module esodo_angdiv #(
    parameter int ANGLE_BITS = esodo_pkg::ANGLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [esodo_pkg::ANG_NW-1:0]  num,
    input  logic [esodo_pkg::ANG_DW-1:0]  den,
    input  logic                          neg,
    output logic [ANGLE_BITS-1:0]         turn,
    output logic                          done
);
    import esodo_pkg::*;

    localparam int STEPS = ANG_NW + ANGLE_BITS + 21;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [ANG_NW-1:0]     num_reg;
    logic [ANG_DW-1:0]     den_reg;
    logic [ANG_DW-1:0]     r_reg;
    logic [ANGLE_BITS-1:0] q_reg;
    logic [ANGLE_BITS-1:0] turn_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  fin_reg;
    logic                  done_reg;
    logic [ANG_DW:0]       trial;
    logic                  ge;
    logic                  rnd;
    logic [ANGLE_BITS-1:0] q_rnd;

    assign trial = {r_reg, num_reg[ANG_NW-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign rnd   = (r_reg >= (den_reg - r_reg));
    assign q_rnd = q_reg + ANGLE_BITS'(rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(STEPS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            neg_reg <= neg;
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[ANG_NW-2:0], 1'b0};
            r_reg   <= ge ? ANG_DW'(trial - {1'b0, den_reg}) : trial[ANG_DW-1:0];
            q_reg   <= {q_reg[ANGLE_BITS-2:0], ge};
        end
        if (fin_reg)
            turn_reg <= neg_reg ? -q_rnd : q_rnd;
    end

    assign turn = turn_reg;
    assign done = done_reg;

endmodule

// File: hdl/esodo_muldiv.sv
// ----------------------------------------------------------------------------
// esodo_muldiv
// serial shift-add multiply then restoring divide, rounded and saturated
// ----------------------------------------------------------------------------
module esodo_muldiv (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [esodo_pkg::MUL_AW-1:0]        a_mag,
    input  logic [esodo_pkg::MUL_BW-1:0]        b_mag,
    input  logic                                neg,
    input  logic [esodo_pkg::DEN_W-1:0]         den,
    output logic signed [esodo_pkg::DEN_W-1:0]  result,
    output logic                                done
);
    import esodo_pkg::*;

    localparam int CNT_W = $clog2(MUL_PW + 1);

    logic [MUL_AW-1:0]        a_reg;
    logic [MUL_BW-1:0]        b_reg;
    logic [MUL_PW-1:0]        p_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         r_reg;
    logic [QMAG_W-1:0]        q_reg;
    logic                     sat_reg;
    logic                     neg_reg;
    logic signed [DEN_W-1:0]  res_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     mul_reg;
    logic                     div_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic [MUL_AW:0]          acc_sum;
    logic [DEN_W-1:0]         trial;
    logic                     ge;
    logic                     rnd;
    logic [QMAG_W-1:0]        mag;

    // lsb-first shift-add: the high half takes the partial product
    assign acc_sum = (MUL_AW+1)'(p_reg[MUL_PW-1:MUL_BW])
                   + (MUL_AW+1)'(b_reg[0] ? a_reg : {MUL_AW{1'b0}});

    assign trial = {r_reg[DEN_W-2:0], p_reg[MUL_PW-1]};
    assign ge    = (trial >= den_reg);
    assign rnd   = !sat_reg && (r_reg >= (den_reg - r_reg));
    assign mag   = sat_reg ? QMAX : (q_reg + QMAG_W'(rnd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mul_reg  <= 1'b0;
            div_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                mul_reg <= 1'b1;
                cnt_reg <= CNT_W'(MUL_BW);
            end
            else if (mul_reg)
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    mul_reg <= 1'b0;
                    div_reg <= 1'b1;
                    cnt_reg <= CNT_W'(MUL_PW);
                end
                else
                    cnt_reg <= cnt_reg - CNT_W'(1);
            end
            else if (div_reg)
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    div_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            p_reg   <= '0;
            den_reg <= den;
            neg_reg <= neg;
            r_reg   <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (mul_reg)
        begin
            p_reg <= {acc_sum, p_reg[MUL_BW-1:1]};
            b_reg <= {1'b0, b_reg[MUL_BW-1:1]};
        end
        else if (div_reg)
        begin
            p_reg   <= {p_reg[MUL_PW-2:0], 1'b0};
            r_reg   <= ge ? (trial - den_reg) : trial;
            q_reg   <= {q_reg[QMAG_W-2:0], ge};
            // quotient reaching 2^62 saturates
            sat_reg <= sat_reg | q_reg[QMAG_W-1] | q_reg[QMAG_W-2];
        end
        if (fin_reg)
            res_reg <= neg_reg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule
